FILE: hdl/csd_pkg.sv
// ----------------------------------------------------------------------------
// csd_pkg
// Shared types, codes and constants of the container stream deframer.
// ----------------------------------------------------------------------------
package csd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned KIND_W    = 3;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned COUNT_W   = 32;
    localparam int unsigned SIZE_W    = 64;
    localparam int unsigned NAMELEN_W = 16;
    localparam int unsigned POS_W     = 4;

    localparam logic [POS_W-1:0] MAGIC_LEN   = 4'd5;
    localparam logic [POS_W-1:0] TOTAL_LEN   = 4'd8;
    localparam logic [POS_W-1:0] COUNT_LEN   = 4'd4;
    localparam logic [POS_W-1:0] NAMELEN_LEN = 4'd2;
    localparam logic [POS_W-1:0] SIZE_LEN    = 4'd8;

    localparam logic [BYTE_W-1:0] CHAR_SLASH     = 8'h2F;
    localparam logic [BYTE_W-1:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CHAR_COLON     = 8'h3A;
    localparam logic [BYTE_W-1:0] CHAR_DOT       = 8'h2E;
    localparam logic [BYTE_W-1:0] CONTROL_LIMIT  = 8'h20;

    localparam logic [KIND_W-1:0] KIND_HEADER    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NAME      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SIZE_DONE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DATA      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_IGNORED   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_END       = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_MAGIC = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TRUNCATED = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_NAME  = 2'd3;

    typedef enum logic [7:0] {
        PH_MAGIC   = 8'b0000_0001,
        PH_TOTAL   = 8'b0000_0010,
        PH_COUNT   = 8'b0000_0100,
        PH_NAMELEN = 8'b0000_1000,
        PH_NAME    = 8'b0001_0000,
        PH_SIZE    = 8'b0010_0000,
        PH_DATA    = 8'b0100_0000,
        PH_TAIL    = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              end_of_stream;
    } item_t;

    typedef struct packed {
        logic       nonzero;
        logic       all_dots;
        logic [1:0] dot_count;
    } comp_t;

    typedef struct packed {
        comp_t comp;
        logic  violation;
        logic  end_bad;
    } name_chk_t;

    function automatic logic [BYTE_W-1:0] magic_byte(input logic [2:0] pos);
        logic [BYTE_W-1:0] value;
        unique case (pos)
            3'd0:    value = 8'h45;
            3'd1:    value = 8'h44;
            3'd2:    value = 8'h42;
            3'd3:    value = 8'h50;
            3'd4:    value = 8'h31;
            default: value = 8'h00;
        endcase
        return value;
    endfunction

    function automatic logic comp_bad(input comp_t comp);
        return !comp.nonzero ||
               (comp.all_dots && (comp.dot_count == 2'd1 || comp.dot_count == 2'd2));
    endfunction

endpackage

FILE: hdl/container_stream_deframer_top.sv
// ----------------------------------------------------------------------------
// container_stream_deframer_top
// Byte-serial container parser with name checking and sticky status.
// ----------------------------------------------------------------------------
// Each accepted request carries one container byte or an end-of-stream mark
// and yields exactly one result. A new request is taken in every cycle while
// results drain. A request is held in the input register until the parser
// takes it. At that edge the parser updates its state and loads the result
// register, which presents the result until it is taken. The single per-byte
// state update, with its 64-bit size countdown, sets the rate of one byte per
// cycle while results drain. in_ready falls only when both the input register
// and the result register are full.
module container_stream_deframer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_value,
    input  logic        end_of_stream,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  out_byte,
    output logic [31:0] member_number,
    output logic        last_in_part,
    output logic [63:0] member_size,
    output logic [63:0] total_size,
    output logic        finished,
    output logic [1:0]  status
);
    import csd_pkg::*;

    logic  take;
    logic  item_valid;
    item_t item;

    csd_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .byte_value    (byte_value),
        .end_of_stream (end_of_stream),
        .take          (take),
        .item_valid    (item_valid),
        .item          (item)
    );

    csd_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item          (item),
        .take          (take),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .out_byte      (out_byte),
        .member_number (member_number),
        .last_in_part  (last_in_part),
        .member_size   (member_size),
        .total_size    (total_size),
        .finished      (finished),
        .status        (status)
    );

endmodule

FILE: hdl/csd_name_check.sv
// ----------------------------------------------------------------------------
// csd_name_check
// Updates the path component tracking and the held name fault for one name byte.
// ----------------------------------------------------------------------------
module csd_name_check (
    input  logic [7:0]     name_byte,
    input  csd_pkg::comp_t comp,
    input  logic           violation,
    output csd_pkg::name_chk_t result
);
    import csd_pkg::*;

    comp_t comp_new;
    logic  viol_new;

    always_comb
    begin
        comp_new = comp;
        viol_new = violation;
        if (name_byte == CHAR_SLASH)
        begin
            viol_new = violation | comp_bad(comp);
            comp_new.nonzero   = 1'b0;
            comp_new.all_dots  = 1'b1;
            comp_new.dot_count = 2'd0;
        end
        else
        begin
            if (name_byte == CHAR_BACKSLASH || name_byte == CHAR_COLON ||
                name_byte < CONTROL_LIMIT)
            begin
                viol_new = 1'b1;
            end
            if (name_byte == CHAR_DOT)
            begin
                if (comp.dot_count != 2'd3)
                begin
                    comp_new.dot_count = comp.dot_count + 2'd1;
                end
            end
            else
            begin
                comp_new.all_dots = 1'b0;
            end
            comp_new.nonzero = 1'b1;
        end
        result.comp      = comp_new;
        result.violation = viol_new;
        result.end_bad   = viol_new | comp_bad(comp_new);
    end

endmodule

FILE: hdl/csd_in_stage.sv
// ----------------------------------------------------------------------------
// csd_in_stage
// Input register holding one request until the parser takes it.
// ----------------------------------------------------------------------------
module csd_in_stage (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                byte_value,
    input  logic                      end_of_stream,
    input  logic                      take,
    output logic                      item_valid,
    output csd_pkg::item_t            item
);
    import csd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.byte_value    <= byte_value;
            item_reg.end_of_stream <= end_of_stream;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: hdl/csd_core.sv
// ----------------------------------------------------------------------------
// csd_core
// Parser state, per-byte update and the result register.
// ----------------------------------------------------------------------------
module csd_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  csd_pkg::item_t       item,
    output logic                 take,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           kind,
    output logic [7:0]           out_byte,
    output logic [31:0]          member_number,
    output logic                 last_in_part,
    output logic [63:0]          member_size,
    output logic [63:0]          total_size,
    output logic                 finished,
    output logic [1:0]           status
);
    import csd_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [POS_W-1:0]     field_position_reg, field_position_next;
    logic [SIZE_W-1:0]    field_shifter_reg, field_shifter_next;
    logic [SIZE_W-1:0]    total_declared_reg, total_declared_next;
    logic [COUNT_W-1:0]   members_left_reg, members_left_next;
    logic [COUNT_W-1:0]   member_counter_reg, member_counter_next;
    logic [NAMELEN_W-1:0] name_bytes_left_reg, name_bytes_left_next;
    logic [SIZE_W-1:0]    data_bytes_left_reg, data_bytes_left_next;
    logic                 magic_mismatch_reg, magic_mismatch_next;
    logic                 name_violation_reg, name_violation_next;
    comp_t                comp_reg, comp_next;
    logic [STATUS_W-1:0]  error_code_reg, error_code_next;
    logic                 done_flag_reg, done_flag_next;

    logic                 out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [BYTE_W-1:0]    out_byte_reg, out_byte_next;
    logic [COUNT_W-1:0]   number_reg;
    logic                 last_reg, last_next;
    logic [SIZE_W-1:0]    msize_reg, msize_next;
    logic [SIZE_W-1:0]    total_reg;
    logic                 finished_reg;
    logic [STATUS_W-1:0]  status_reg;

    logic [SIZE_W-1:0]    shift_new;
    logic [POS_W-1:0]     pos_new;
    logic [SIZE_W-1:0]    data_dec;
    logic [NAMELEN_W-1:0] name_dec;
    logic [COUNT_W-1:0]   members_dec;
    logic [POS_W-1:0]     need;
    logic                 field_done;
    name_chk_t            chk;
    comp_t                comp_clear;

    csd_name_check u_name_check (
        .name_byte (item.byte_value),
        .comp      (comp_reg),
        .violation (name_violation_reg),
        .result    (chk)
    );

    assign take           = item_valid && (!out_valid_reg || out_ready);
    assign out_valid_next = take || (out_valid_reg && !out_ready);

    assign shift_new   = {field_shifter_reg[SIZE_W-BYTE_W-1:0], item.byte_value};
    assign pos_new     = field_position_reg + 4'd1;
    assign data_dec    = data_bytes_left_reg - 64'd1;
    assign name_dec    = name_bytes_left_reg - 16'd1;
    assign members_dec = members_left_reg - 32'd1;
    assign comp_clear  = '{nonzero: 1'b0, all_dots: 1'b1, dot_count: 2'd0};

    always_comb
    begin
        unique case (phase_reg)
            PH_MAGIC:   need = MAGIC_LEN;
            PH_TOTAL:   need = TOTAL_LEN;
            PH_COUNT:   need = COUNT_LEN;
            PH_NAMELEN: need = NAMELEN_LEN;
            default:    need = SIZE_LEN;
        endcase
    end

    assign field_done = (pos_new >= need);

    always_comb
    begin
        phase_next           = phase_reg;
        field_position_next  = field_position_reg;
        field_shifter_next   = field_shifter_reg;
        total_declared_next  = total_declared_reg;
        members_left_next    = members_left_reg;
        member_counter_next  = member_counter_reg;
        name_bytes_left_next = name_bytes_left_reg;
        data_bytes_left_next = data_bytes_left_reg;
        magic_mismatch_next  = magic_mismatch_reg;
        name_violation_next  = name_violation_reg;
        comp_next            = comp_reg;
        error_code_next      = error_code_reg;
        done_flag_next       = done_flag_reg;
        kind_next            = KIND_IGNORED;
        out_byte_next        = '0;
        last_next            = 1'b0;
        msize_next           = '0;

        if (item.end_of_stream)
        begin
            kind_next = KIND_END;
            if (error_code_reg == STATUS_OK && !done_flag_reg)
            begin
                error_code_next = STATUS_TRUNCATED;
            end
        end
        else if (error_code_reg == STATUS_OK && !done_flag_reg)
        begin
            unique case (phase_reg)
                PH_MAGIC, PH_TOTAL, PH_COUNT, PH_NAMELEN, PH_SIZE:
                begin
                    kind_next           = KIND_HEADER;
                    field_shifter_next  = shift_new;
                    field_position_next = field_done ? '0 : pos_new;
                    if (phase_reg == PH_MAGIC && field_position_reg < MAGIC_LEN &&
                        item.byte_value != magic_byte(field_position_reg[2:0]))
                    begin
                        magic_mismatch_next = 1'b1;
                    end
                    if (field_done)
                    begin
                        field_shifter_next = '0;
                        unique case (phase_reg)
                            PH_MAGIC:
                            begin
                                if (magic_mismatch_next)
                                begin
                                    error_code_next = STATUS_BAD_MAGIC;
                                end
                                else
                                begin
                                    phase_next = PH_TOTAL;
                                end
                            end
                            PH_TOTAL:
                            begin
                                total_declared_next = shift_new;
                                phase_next          = PH_COUNT;
                            end
                            PH_COUNT:
                            begin
                                members_left_next = shift_new[COUNT_W-1:0];
                                if (shift_new[COUNT_W-1:0] == '0)
                                begin
                                    done_flag_next = 1'b1;
                                    phase_next     = PH_TAIL;
                                end
                                else
                                begin
                                    phase_next = PH_NAMELEN;
                                end
                            end
                            PH_NAMELEN:
                            begin
                                name_bytes_left_next = shift_new[NAMELEN_W-1:0];
                                name_violation_next  = 1'b0;
                                comp_next            = comp_clear;
                                if (shift_new[NAMELEN_W-1:0] == '0)
                                begin
                                    error_code_next = STATUS_BAD_NAME;
                                end
                                else
                                begin
                                    phase_next = PH_NAME;
                                end
                            end
                            default:
                            begin
                                kind_next            = KIND_SIZE_DONE;
                                msize_next           = shift_new;
                                data_bytes_left_next = shift_new;
                                if (shift_new == '0)
                                begin
                                    last_next           = 1'b1;
                                    members_left_next   = members_dec;
                                    member_counter_next = member_counter_reg + 32'd1;
                                    if (members_dec == '0)
                                    begin
                                        done_flag_next = 1'b1;
                                        phase_next     = PH_TAIL;
                                    end
                                    else
                                    begin
                                        phase_next = PH_NAMELEN;
                                    end
                                end
                                else
                                begin
                                    phase_next = PH_DATA;
                                end
                            end
                        endcase
                    end
                end
                PH_NAME:
                begin
                    kind_next            = KIND_NAME;
                    out_byte_next        = item.byte_value;
                    comp_next            = chk.comp;
                    name_violation_next  = chk.violation;
                    name_bytes_left_next = name_dec;
                    if (name_dec == '0)
                    begin
                        last_next = 1'b1;
                        if (chk.end_bad)
                        begin
                            error_code_next = STATUS_BAD_NAME;
                        end
                        else
                        begin
                            phase_next = PH_SIZE;
                        end
                        name_violation_next = 1'b0;
                        comp_next           = comp_clear;
                    end
                end
                PH_DATA:
                begin
                    kind_next            = KIND_DATA;
                    out_byte_next        = item.byte_value;
                    data_bytes_left_next = data_dec;
                    if (data_dec == '0)
                    begin
                        last_next           = 1'b1;
                        members_left_next   = members_dec;
                        member_counter_next = member_counter_reg + 32'd1;
                        if (members_dec == '0)
                        begin
                            done_flag_next = 1'b1;
                            phase_next     = PH_TAIL;
                        end
                        else
                        begin
                            phase_next = PH_NAMELEN;
                        end
                    end
                end
                default:
                begin
                    kind_next = KIND_IGNORED;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_MAGIC;
            field_position_reg  <= '0;
            field_shifter_reg   <= '0;
            total_declared_reg  <= '0;
            members_left_reg    <= '0;
            member_counter_reg  <= '0;
            name_bytes_left_reg <= '0;
            data_bytes_left_reg <= '0;
            magic_mismatch_reg  <= 1'b0;
            name_violation_reg  <= 1'b0;
            comp_reg            <= '{nonzero: 1'b0, all_dots: 1'b1, dot_count: 2'd0};
            error_code_reg      <= STATUS_OK;
            done_flag_reg       <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                phase_reg           <= phase_next;
                field_position_reg  <= field_position_next;
                field_shifter_reg   <= field_shifter_next;
                total_declared_reg  <= total_declared_next;
                members_left_reg    <= members_left_next;
                member_counter_reg  <= member_counter_next;
                name_bytes_left_reg <= name_bytes_left_next;
                data_bytes_left_reg <= data_bytes_left_next;
                magic_mismatch_reg  <= magic_mismatch_next;
                name_violation_reg  <= name_violation_next;
                comp_reg            <= comp_next;
                error_code_reg      <= error_code_next;
                done_flag_reg       <= done_flag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg     <= kind_next;
            out_byte_reg <= out_byte_next;
            number_reg   <= member_counter_reg;
            last_reg     <= last_next;
            msize_reg    <= msize_next;
            total_reg    <= total_declared_next;
            finished_reg <= done_flag_next;
            status_reg   <= error_code_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign out_byte      = out_byte_reg;
    assign member_number = number_reg;
    assign last_in_part  = last_reg;
    assign member_size   = msize_reg;
    assign total_size    = total_reg;
    assign finished      = finished_reg;
    assign status        = status_reg;

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the container stream deframer.
// ----------------------------------------------------------------------------
// One container is streamed per run, since status is sticky and reset comes
// only once: a header, a directed member, four stretches of random members
// under different idling, then an ending picked at random (clean finish,
// truncation, unsafe or empty name, bad magic or no members) and a tail of
// ignored bytes and end marks. Every accepted request is run through a
// behavioural parser and its result is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import csd_pkg::*;

    localparam int STUCK_LIMIT = 2000;
    localparam int MEMBERS_PER_PHASE = 6;
    localparam int PHASE_COUNT = 4;
    localparam logic [39:0] MAGIC_WORD = 40'h45_44_42_50_31;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [31:0] member;
        logic        last;
        logic [63:0] size;
        logic [63:0] total;
        logic        done;
        logic [1:0]  status;
    } deframe_result_t;

    typedef enum int {
        END_CLEAN, END_BAD_MAGIC, END_NO_MEMBERS, END_CUT_DATA,
        END_CUT_NAME, END_CUT_SIZE, END_UNSAFE_NAME, END_EMPTY_NAME
    } ending_t;

    typedef enum int {
        FAULT_LEADING, FAULT_DOUBLE, FAULT_TRAILING, FAULT_BACKSLASH, FAULT_COLON,
        FAULT_CONTROL, FAULT_DOT, FAULT_DOTDOT, FAULT_INNER_DOT, FAULT_INNER_DOTDOT,
        FAULT_SLASH_ONLY
    } name_fault_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  byte_value = 8'h00;
    logic        end_of_stream = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  out_byte;
    logic [31:0] member_number;
    logic        last_in_part;
    logic [63:0] member_size;
    logic [63:0] total_size;
    logic        finished;
    logic [1:0]  status;

    item_t           container_bytes[$];
    deframe_result_t predicted_records[$];
    logic [7:0]      name_buf[$];
    int              bytes_queued = 0;
    int              records_checked = 0;
    int              n_errors = 0;
    int              stuck_cycles = 0;
    int unsigned     send_idle_pct = 0;
    int unsigned     stall_pct = 0;
    logic            rx_hold = 1'b0;
    logic            req_taken = 1'b0;
    logic            resp_taken = 1'b0;

    // Parser state of the predictor.
    phase_t      st_phase = PH_MAGIC;
    logic [3:0]  st_pos = '0;
    logic [63:0] st_shift = '0;
    logic [63:0] st_total = '0;
    logic [31:0] st_left = '0;
    logic [31:0] st_member = '0;
    logic [15:0] st_name_left = '0;
    logic [63:0] st_data_left = '0;
    logic        st_magic_bad = 1'b0;
    logic        st_name_bad = 1'b0;
    logic        part_nonzero = 1'b0;
    logic        part_all_dots = 1'b1;
    logic [1:0]  part_dots = '0;
    logic [1:0]  st_status = STATUS_OK;
    logic        st_done = 1'b0;

    container_stream_deframer_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .byte_value(byte_value),
        .end_of_stream(end_of_stream),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .kind(kind),
        .out_byte(out_byte),
        .member_number(member_number),
        .last_in_part(last_in_part),
        .member_size(member_size),
        .total_size(total_size),
        .finished(finished),
        .status(status)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic shift_field(input logic [7:0] b, input logic [3:0] need);
        st_shift = {st_shift[55:0], b};
        st_pos = st_pos + 4'd1;
        if (st_pos >= need)
        begin
            st_pos = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic part_is_bad();
        return !part_nonzero || (part_all_dots && (part_dots == 2'd1 || part_dots == 2'd2));
    endfunction

    function automatic void part_clear();
        part_nonzero = 1'b0;
        part_all_dots = 1'b1;
        part_dots = '0;
    endfunction

    function automatic void member_close();
        st_left = st_left - 32'd1;
        st_member = st_member + 32'd1;
        if (st_left == '0)
        begin
            st_done = 1'b1;
            st_phase = PH_TAIL;
        end
        else
        begin
            st_phase = PH_NAMELEN;
        end
    endfunction

    function automatic deframe_result_t deframe_predict(input logic [7:0] b, input logic eos);
        deframe_result_t r;
        r = '0;
        r.kind = KIND_IGNORED;
        r.member = st_member;
        if (eos)
        begin
            r.kind = KIND_END;
            if (st_status == STATUS_OK && !st_done)
                st_status = STATUS_TRUNCATED;
        end
        else if (st_status == STATUS_OK && !st_done)
        begin
            case (st_phase)
                PH_MAGIC:
                begin
                    r.kind = KIND_HEADER;
                    if (b != MAGIC_WORD[8 * (4 - st_pos) +: 8])
                        st_magic_bad = 1'b1;
                    if (shift_field(b, MAGIC_LEN))
                    begin
                        if (st_magic_bad)
                            st_status = STATUS_BAD_MAGIC;
                        else
                            st_phase = PH_TOTAL;
                        st_shift = '0;
                    end
                end
                PH_TOTAL:
                begin
                    r.kind = KIND_HEADER;
                    if (shift_field(b, TOTAL_LEN))
                    begin
                        st_total = st_shift;
                        st_shift = '0;
                        st_phase = PH_COUNT;
                    end
                end
                PH_COUNT:
                begin
                    r.kind = KIND_HEADER;
                    if (shift_field(b, COUNT_LEN))
                    begin
                        st_left = st_shift[31:0];
                        st_shift = '0;
                        if (st_left == '0)
                        begin
                            st_done = 1'b1;
                            st_phase = PH_TAIL;
                        end
                        else
                        begin
                            st_phase = PH_NAMELEN;
                        end
                    end
                end
                PH_NAMELEN:
                begin
                    r.kind = KIND_HEADER;
                    if (shift_field(b, NAMELEN_LEN))
                    begin
                        st_name_left = st_shift[15:0];
                        st_shift = '0;
                        st_name_bad = 1'b0;
                        part_clear();
                        if (st_name_left == '0)
                            st_status = STATUS_BAD_NAME;
                        else
                            st_phase = PH_NAME;
                    end
                end
                PH_NAME:
                begin
                    r.kind = KIND_NAME;
                    r.data = b;
                    if (b == CHAR_SLASH)
                    begin
                        if (part_is_bad())
                            st_name_bad = 1'b1;
                        part_clear();
                    end
                    else
                    begin
                        if (b == CHAR_BACKSLASH || b == CHAR_COLON || b < CONTROL_LIMIT)
                            st_name_bad = 1'b1;
                        if (b == CHAR_DOT)
                        begin
                            if (part_dots != 2'd3)
                                part_dots = part_dots + 2'd1;
                        end
                        else
                        begin
                            part_all_dots = 1'b0;
                        end
                        part_nonzero = 1'b1;
                    end
                    st_name_left = st_name_left - 16'd1;
                    if (st_name_left == '0)
                    begin
                        r.last = 1'b1;
                        if (part_is_bad())
                            st_name_bad = 1'b1;
                        if (st_name_bad)
                            st_status = STATUS_BAD_NAME;
                        else
                            st_phase = PH_SIZE;
                        st_name_bad = 1'b0;
                        part_clear();
                    end
                end
                PH_SIZE:
                begin
                    r.kind = KIND_HEADER;
                    if (shift_field(b, SIZE_LEN))
                    begin
                        r.kind = KIND_SIZE_DONE;
                        r.size = st_shift;
                        st_data_left = st_shift;
                        st_shift = '0;
                        if (r.size == '0)
                        begin
                            r.last = 1'b1;
                            member_close();
                        end
                        else
                        begin
                            st_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    r.kind = KIND_DATA;
                    r.data = b;
                    st_data_left = st_data_left - 64'd1;
                    if (st_data_left == '0)
                    begin
                        r.last = 1'b1;
                        member_close();
                    end
                end
                default:
                begin
                    r.kind = KIND_IGNORED;
                end
            endcase
        end
        r.total = st_total;
        r.done = st_done;
        r.status = st_status;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (n_errors < 40)
            $display("mismatch at result %0d: %s is %0h, expected %0h",
                     records_checked, what, got, want);
        n_errors++;
    endtask

    task automatic push_req(input logic [7:0] b, input logic eos);
        item_t it;
        it.byte_value = b;
        it.end_of_stream = eos;
        container_bytes.push_back(it);
        bytes_queued++;
    endtask

    task automatic push_field(input logic [63:0] value, input int nbytes);
        for (int i = nbytes - 1; i >= 0; i--)
            push_req(value[8 * i +: 8], 1'b0);
    endtask

    task automatic push_noise(input int n);
        repeat (n) push_req(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic push_member(input logic [63:0] size, input int data_bytes);
        push_field(64'(name_buf.size()), 2);
        foreach (name_buf[i])
            push_req(name_buf[i], 1'b0);
        push_field(size, 8);
        push_noise(data_bytes);
    endtask

    task automatic append_text(input string s);
        for (int i = 0; i < s.len(); i++)
            name_buf.push_back(s[i]);
    endtask

    task automatic make_valid_name();
        int parts;
        int len;
        logic [7:0] c;
        logic dots_only;
        name_buf.delete();
        parts = $urandom_range(1, 3);
        for (int p = 0; p < parts; p++)
        begin
            if (p != 0)
                name_buf.push_back(CHAR_SLASH);
            len = $urandom_range(1, 4);
            dots_only = 1'b1;
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    c = CHAR_DOT;
                end
                else
                begin
                    c = 8'($urandom_range(32, 255));
                    if (c == CHAR_SLASH || c == CHAR_BACKSLASH || c == CHAR_COLON)
                        c = 8'h61;
                end
                if (c != CHAR_DOT)
                    dots_only = 1'b0;
                name_buf.push_back(c);
            end
            // A component of one or two dots only would be refused, so extend it.
            if (dots_only && len < 3)
                name_buf.push_back(8'h5F);
        end
    endtask

    task automatic make_unsafe_name();
        name_buf.delete();
        case (name_fault_t'($urandom_range(0, 10)))
            FAULT_LEADING:      append_text("/a");
            FAULT_DOUBLE:       append_text("a//b");
            FAULT_TRAILING:     append_text("a/");
            FAULT_BACKSLASH:    append_text("a\\b");
            FAULT_COLON:        append_text("c:");
            FAULT_CONTROL:
            begin
                append_text("a");
                name_buf.push_back(8'($urandom_range(0, 31)));
                append_text("b");
            end
            FAULT_DOT:          append_text(".");
            FAULT_DOTDOT:       append_text("..");
            FAULT_INNER_DOT:    append_text("a/./b");
            FAULT_INNER_DOTDOT: append_text("x/../y");
            default:            append_text("/");
        endcase
    endtask

    task automatic wait_for_drain();
        while (records_checked != bytes_queued)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic push_random_members(input int n);
        logic [63:0] size;
        repeat (n)
        begin
            make_valid_name();
            if ($urandom_range(0, 5) == 0)
                size = 64'($urandom_range(9, 40));
            else
                size = 64'($urandom_range(0, 8));
            push_member(size, int'(size));
        end
    endtask

    always @(posedge clk)
    begin : request_capture
        req_taken <= in_valid && in_ready;
        if (in_valid && in_ready)
            predicted_records.push_back(deframe_predict(byte_value, end_of_stream));
    end

    always @(negedge clk)
    begin : request_driver
        item_t nxt;
        if (!in_valid || req_taken)
        begin
            if (container_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                nxt = container_bytes.pop_front();
                in_valid <= 1'b1;
                byte_value <= nxt.byte_value;
                end_of_stream <= nxt.end_of_stream;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : result_ready_driver
        out_ready <= !rx_hold && ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin : result_monitor
        deframe_result_t want;
        resp_taken <= rst_n && out_valid && out_ready;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (predicted_records.size() == 0)
            begin
                flag_mismatch("result with no request outstanding, kind", 64'(kind), '0);
            end
            else
            begin
                want = predicted_records.pop_front();
                records_checked <= records_checked + 1;
                if (kind !== want.kind)
                    flag_mismatch("kind", 64'(kind), 64'(want.kind));
                if (out_byte !== want.data)
                    flag_mismatch("out_byte", 64'(out_byte), 64'(want.data));
                if (member_number !== want.member)
                    flag_mismatch("member_number", 64'(member_number), 64'(want.member));
                if (last_in_part !== want.last)
                    flag_mismatch("last_in_part", 64'(last_in_part), 64'(want.last));
                if (member_size !== want.size)
                    flag_mismatch("member_size", member_size, want.size);
                if (total_size !== want.total)
                    flag_mismatch("total_size", total_size, want.total);
                if (finished !== want.done)
                    flag_mismatch("finished", 64'(finished), 64'(want.done));
                if (status !== want.status)
                    flag_mismatch("status", 64'(status), 64'(want.status));
            end
        end
    end

    always @(negedge clk)
    begin : watchdog
        if (req_taken || resp_taken || records_checked == bytes_queued)
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("no request or result moved for %0d cycles", STUCK_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin : stimulus
        ending_t ending;
        int pick;
        logic [39:0] magic;
        logic [63:0] total;
        logic [31:0] count;
        logic [63:0] cut_size;
        logic [15:0] cut_len;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        pick = $urandom_range(0, 15);
        if (pick == 0)
            ending = END_BAD_MAGIC;
        else if (pick == 1)
            ending = END_NO_MEMBERS;
        else if (pick < 5)
            ending = END_CLEAN;
        else if (pick < 8)
            ending = END_CUT_DATA;
        else if (pick < 10)
            ending = END_CUT_NAME;
        else if (pick < 12)
            ending = END_CUT_SIZE;
        else if (pick < 15)
            ending = END_UNSAFE_NAME;
        else
            ending = END_EMPTY_NAME;

        magic = MAGIC_WORD;
        if (ending == END_BAD_MAGIC)
            magic = magic ^ (40'($urandom_range(1, 255)) << (8 * $urandom_range(0, 4)));
        case ($urandom_range(0, 2))
            0:       total = '0;
            1:       total = '1;
            default: total = {$urandom, $urandom};
        endcase
        if (ending == END_CLEAN)
            count = 32'(1 + PHASE_COUNT * MEMBERS_PER_PHASE);
        else if (ending == END_NO_MEMBERS)
            count = '0;
        else if ($urandom_range(0, 1) != 0)
            count = '1;
        else
            count = $urandom | 32'h8000_0000;

        // Header and a directed member: a run of four dots, a space, a top-bit
        // byte and a zero size.
        push_field(64'(magic), 5);
        push_field(total, 8);
        push_field(64'(count), 4);
        name_buf.delete();
        append_text("..../ ");
        name_buf.push_back(8'hFF);
        push_member('0, 0);
        wait_for_drain();

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 67;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 67;
                end
                default:
                begin
                    send_idle_pct = 30;
                    stall_pct = 30;
                end
            endcase
            push_random_members(MEMBERS_PER_PHASE);
            if (ph == 0)
            begin
                // Hold results back so the block fills and refuses requests.
                rx_hold = 1'b1;
                repeat (80) @(posedge clk);
                rx_hold = 1'b0;
            end
            wait_for_drain();
        end

        case (ending)
            END_CUT_DATA:
            begin
                make_valid_name();
                cut_size = {$urandom, $urandom};
                cut_size[63] = 1'b1;
                if ($urandom_range(0, 1) != 0)
                    cut_size = '1;
                push_member(cut_size, $urandom_range(1, 12));
            end
            END_CUT_NAME:
            begin
                cut_len = ($urandom_range(0, 1) != 0) ? 16'hFFFF
                                                      : 16'($urandom_range(20, 65535));
                push_field(64'(cut_len), 2);
                push_noise(10);
            end
            END_CUT_SIZE:
            begin
                make_valid_name();
                push_field(64'(name_buf.size()), 2);
                foreach (name_buf[i])
                    push_req(name_buf[i], 1'b0);
                push_noise($urandom_range(1, 7));
            end
            END_UNSAFE_NAME:
            begin
                make_unsafe_name();
                push_member(64'd2, 2);
            end
            END_EMPTY_NAME:
            begin
                push_field('0, 2);
            end
            default:
            begin
            end
        endcase
        push_noise(5);
        push_req(8'($urandom_range(0, 255)), 1'b1);
        push_noise(3);
        push_req(8'($urandom_range(0, 255)), 1'b1);
        wait_for_drain();

        repeat (6) @(posedge clk);
        if (predicted_records.size() != 0)
            flag_mismatch("results never delivered", 64'(predicted_records.size()), '0);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
hdl/csd_pkg.sv
hdl/csd_name_check.sv
hdl/csd_in_stage.sv
hdl/csd_core.sv
hdl/container_stream_deframer_top.sv
sim/tb_top.sv
